// ===== rtl/core/ccit_pkg.sv =====
`default_nettype none
package ccit_pkg;

    localparam int COORD_BITS  = 16;
    localparam int CENTER_BITS = 32;
    localparam int QUOT_BITS   = CENTER_BITS;
    // |det| = 4 * |cross product of a pair of edge vectors|, below 2^35 for 16-bit coordinates
    localparam int DEN_BITS    = 2 * COORD_BITS + 4;
    localparam int DIV_STAGES  = QUOT_BITS;
    localparam int LANES       = 2;
    localparam int LANE_X      = 0;
    localparam int LANE_Y      = 1;

    localparam logic [QUOT_BITS-1:0] SAT_POS_MAG = {1'b0, {(QUOT_BITS-1){1'b1}}};
    localparam logic [QUOT_BITS-1:0] SAT_NEG_MAG = {1'b1, {(QUOT_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by_coord;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] query_x;
        logic signed [COORD_BITS-1:0] query_y;
    } ccit_in_t;

    typedef struct packed {
        logic signed [CENTER_BITS-1:0] center_x;
        logic signed [CENTER_BITS-1:0] center_y;
        logic                          inside_res;
        logic                          degenerate;
        logic                          saturated;
    } ccit_out_t;

    // one stage of the two-lane restoring divider plus sideband flags
    typedef struct packed {
        logic [LANES-1:0][DEN_BITS-1:0]  rem;
        logic [LANES-1:0][QUOT_BITS-1:0] lo;
        logic [LANES-1:0][QUOT_BITS-1:0] quot;
        logic [DEN_BITS-1:0]             den;
        logic [LANES-1:0]                ovf;
        logic [LANES-1:0]                neg;
        logic                            in_circle;
        logic                            degen;
    } div_stage_t;

endpackage
`default_nettype wire

// ===== rtl/core/circumcircle_in_circle_test.sv =====
// Pipeline: an accepted input word passes 6 math stages, 32 divider stages and
// 1 output register to reach its result word; the restoring divider sets the depth.
// Throughput: one word per cycle when the output side does not stall.
// Reset: synchronous, active low aresetn clears all stage valid bits and the
// output valid; data registers are not reset.
`default_nettype none
module circumcircle_in_circle_test #(
    parameter int FRAC_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ccit_pkg::ccit_in_t   s_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ccit_pkg::ccit_out_t  m_word
);
    import ccit_pkg::*;

    localparam int DIFF_W  = COORD_BITS + 1;         // coordinate difference
    localparam int SQ_W    = 2 * COORD_BITS;         // x^2 + y^2 of one point
    localparam int C_W     = 2 * COORD_BITS + 1;     // c1, c2
    localparam int LIFT_W  = 2 * COORD_BITS + 1;     // |p - q|^2, unsigned
    localparam int CROSS_W = 2 * COORD_BITS + 2;     // 2x2 minor
    localparam int LO_W    = COORD_BITS + 1;         // low slice of a minor
    localparam int HI_W    = CROSS_W - LO_W;
    localparam int PLO_W   = LIFT_W + 1 + LO_W + 1;
    localparam int PHI_W   = LIFT_W + 1 + HI_W;
    localparam int TERM_W  = LIFT_W + CROSS_W + 1;
    localparam int IC_W    = TERM_W + 2;             // in-circle determinant
    localparam int NX_W    = 3 * COORD_BITS + 3;     // center numerators
    localparam int NUM_W   = NX_W + FRAC_BITS;       // scaled numerator magnitude
    localparam int TOP_W   = NUM_W - QUOT_BITS;      // part above the quotient bits
    localparam int CMP_W   = (TOP_W > DEN_BITS) ? TOP_W : DEN_BITS;

    // ---------------------------------------------------------------------
    // Pipeline control: the whole pipe advances together when the output
    // register is free or being drained. Valid bits shift with the data.
    // ---------------------------------------------------------------------
    logic        m_valid_reg;
    ccit_out_t   m_word_reg;
    logic        en;
    logic [5:0]  vld_reg;     // stages 1..6

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], s_valid};
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: input register
    // ---------------------------------------------------------------------
    ccit_in_t s1_in_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_in_reg <= s_word;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: edge vectors, vertex offsets from the query point, squares
    // ---------------------------------------------------------------------
    logic signed [DIFF_W-1:0] s2_a1h_next, s2_b1h_next, s2_a2h_next, s2_b2h_next;
    logic signed [DIFF_W-1:0] s2_a1h_reg,  s2_b1h_reg,  s2_a2h_reg,  s2_b2h_reg;
    logic signed [DIFF_W-1:0] s2_dx_next [3];
    logic signed [DIFF_W-1:0] s2_dy_next [3];
    logic signed [DIFF_W-1:0] s2_dx_reg  [3];
    logic signed [DIFF_W-1:0] s2_dy_reg  [3];
    logic        [SQ_W-1:0]   s2_sa_next, s2_sb_next, s2_sc_next;
    logic        [SQ_W-1:0]   s2_sa_reg,  s2_sb_reg,  s2_sc_reg;

    always_comb begin
        // half of the bisector coefficients: a1 = 2*a1h etc.
        s2_a1h_next = s1_in_reg.bx - s1_in_reg.ax;
        s2_b1h_next = s1_in_reg.by_coord - s1_in_reg.ay;
        s2_a2h_next = s1_in_reg.cx - s1_in_reg.bx;
        s2_b2h_next = s1_in_reg.cy - s1_in_reg.by_coord;
        s2_dx_next[0] = s1_in_reg.ax - s1_in_reg.query_x;
        s2_dy_next[0] = s1_in_reg.ay - s1_in_reg.query_y;
        s2_dx_next[1] = s1_in_reg.bx - s1_in_reg.query_x;
        s2_dy_next[1] = s1_in_reg.by_coord - s1_in_reg.query_y;
        s2_dx_next[2] = s1_in_reg.cx - s1_in_reg.query_x;
        s2_dy_next[2] = s1_in_reg.cy - s1_in_reg.query_y;
        s2_sa_next = s1_in_reg.ax * s1_in_reg.ax + s1_in_reg.ay * s1_in_reg.ay;
        s2_sb_next = s1_in_reg.bx * s1_in_reg.bx
                   + s1_in_reg.by_coord * s1_in_reg.by_coord;
        s2_sc_next = s1_in_reg.cx * s1_in_reg.cx + s1_in_reg.cy * s1_in_reg.cy;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_a1h_reg <= s2_a1h_next;
            s2_b1h_reg <= s2_b1h_next;
            s2_a2h_reg <= s2_a2h_next;
            s2_b2h_reg <= s2_b2h_next;
            s2_dx_reg  <= s2_dx_next;
            s2_dy_reg  <= s2_dy_next;
            s2_sa_reg  <= s2_sa_next;
            s2_sb_reg  <= s2_sb_next;
            s2_sc_reg  <= s2_sc_next;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: determinant, right-hand sides, lifts and minors for the
    // in-circle determinant (translated so the query point is the origin)
    // ---------------------------------------------------------------------
    logic signed [DEN_BITS-1:0] s3_det_next, s3_det_reg;
    logic signed [C_W-1:0]      s3_c1_next, s3_c2_next, s3_c1_reg, s3_c2_reg;
    logic        [LIFT_W-1:0]   s3_lift_next  [3];
    logic        [LIFT_W-1:0]   s3_lift_reg   [3];
    logic signed [CROSS_W-1:0]  s3_cross_next [3];
    logic signed [CROSS_W-1:0]  s3_cross_reg  [3];
    logic signed [DIFF_W-1:0]   s3_a1h_reg, s3_b1h_reg, s3_a2h_reg, s3_b2h_reg;

    always_comb begin
        s3_det_next = (s2_a1h_reg * s2_b2h_reg - s2_a2h_reg * s2_b1h_reg) <<< 2;
        s3_c1_next  = $signed({1'b0, s2_sb_reg}) - $signed({1'b0, s2_sa_reg});
        s3_c2_next  = $signed({1'b0, s2_sc_reg}) - $signed({1'b0, s2_sb_reg});
        for (int k = 0; k < 3; k++) begin
            s3_lift_next[k] = s2_dx_reg[k] * s2_dx_reg[k] + s2_dy_reg[k] * s2_dy_reg[k];
        end
        // minor k pairs the other two vertices, in cyclic order
        s3_cross_next[0] = s2_dx_reg[1] * s2_dy_reg[2] - s2_dx_reg[2] * s2_dy_reg[1];
        s3_cross_next[1] = s2_dx_reg[2] * s2_dy_reg[0] - s2_dx_reg[0] * s2_dy_reg[2];
        s3_cross_next[2] = s2_dx_reg[0] * s2_dy_reg[1] - s2_dx_reg[1] * s2_dy_reg[0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_det_reg   <= s3_det_next;
            s3_c1_reg    <= s3_c1_next;
            s3_c2_reg    <= s3_c2_next;
            s3_lift_reg  <= s3_lift_next;
            s3_cross_reg <= s3_cross_next;
            s3_a1h_reg   <= s2_a1h_reg;
            s3_b1h_reg   <= s2_b1h_reg;
            s3_a2h_reg   <= s2_a2h_reg;
            s3_b2h_reg   <= s2_b2h_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 4: center numerators (Cramer), split partial products of
    // lift * minor, zero-determinant detect
    // ---------------------------------------------------------------------
    logic signed [NX_W-1:0]     s4_nx_next, s4_ny_next, s4_nx_reg, s4_ny_reg;
    logic signed [PLO_W-1:0]    s4_plo_next [3];
    logic signed [PLO_W-1:0]    s4_plo_reg  [3];
    logic signed [PHI_W-1:0]    s4_phi_next [3];
    logic signed [PHI_W-1:0]    s4_phi_reg  [3];
    logic signed [DEN_BITS-1:0] s4_det_reg;
    logic                       s4_degen_next, s4_degen_reg;

    always_comb begin
        s4_nx_next = (s3_c1_reg * s3_b2h_reg - s3_c2_reg * s3_b1h_reg) <<< 1;
        s4_ny_next = (s3_c2_reg * s3_a1h_reg - s3_c1_reg * s3_a2h_reg) <<< 1;
        for (int k = 0; k < 3; k++) begin
            s4_plo_next[k] = $signed({1'b0, s3_lift_reg[k]})
                           * $signed({1'b0, s3_cross_reg[k][LO_W-1:0]});
            s4_phi_next[k] = $signed({1'b0, s3_lift_reg[k]})
                           * $signed(s3_cross_reg[k][CROSS_W-1:LO_W]);
        end
        s4_degen_next = (s3_det_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_nx_reg    <= s4_nx_next;
            s4_ny_reg    <= s4_ny_next;
            s4_plo_reg   <= s4_plo_next;
            s4_phi_reg   <= s4_phi_next;
            s4_det_reg   <= s3_det_reg;
            s4_degen_reg <= s4_degen_next;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 5: recombine partial products, take magnitudes for the divider
    // ---------------------------------------------------------------------
    logic signed [TERM_W-1:0]          s5_term_next [3];
    logic signed [TERM_W-1:0]          s5_term_reg  [3];
    logic [LANES-1:0][NX_W-1:0]        s5_mag;
    logic [LANES-1:0][NUM_W-1:0]       s5_num_next, s5_num_reg;
    logic [LANES-1:0]                  s5_neg_next, s5_neg_reg;
    logic [DEN_BITS-1:0]               s5_den_next, s5_den_reg;
    logic                              s5_det_neg_reg, s5_degen_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s5_term_next[k] = (s4_phi_reg[k] <<< LO_W) + s4_plo_reg[k];
        end
        s5_mag[LANE_X] = s4_nx_reg[NX_W-1] ? NX_W'(-s4_nx_reg) : NX_W'(s4_nx_reg);
        s5_mag[LANE_Y] = s4_ny_reg[NX_W-1] ? NX_W'(-s4_ny_reg) : NX_W'(s4_ny_reg);
        for (int l = 0; l < LANES; l++) begin
            s5_num_next[l] = NUM_W'(s5_mag[l]) << FRAC_BITS;
        end
        s5_neg_next[LANE_X] = s4_nx_reg[NX_W-1] ^ s4_det_reg[DEN_BITS-1];
        s5_neg_next[LANE_Y] = s4_ny_reg[NX_W-1] ^ s4_det_reg[DEN_BITS-1];
        s5_den_next = s4_det_reg[DEN_BITS-1] ? DEN_BITS'(-s4_det_reg)
                                             : DEN_BITS'(s4_det_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_term_reg    <= s5_term_next;
            s5_num_reg     <= s5_num_next;
            s5_neg_reg     <= s5_neg_next;
            s5_den_reg     <= s5_den_next;
            s5_det_neg_reg <= s4_det_reg[DEN_BITS-1];
            s5_degen_reg   <= s4_degen_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 6: in-circle sign, divider setup. The quotient is only built to
    // 32 bits; if the numerator bits above those reach the divisor the
    // quotient is at least 2^32 and the lane saturates.
    // ---------------------------------------------------------------------
    logic signed [IC_W-1:0]       s6_ic;
    logic [LANES-1:0][TOP_W-1:0]  s6_top;
    div_stage_t                   s6_div_next, s6_div_reg;

    always_comb begin
        s6_ic = s5_term_reg[0] + s5_term_reg[1] + s5_term_reg[2];
        s6_div_next = '0;
        for (int l = 0; l < LANES; l++) begin
            s6_top[l]             = s5_num_reg[l][NUM_W-1:QUOT_BITS];
            s6_div_next.ovf[l]    = CMP_W'(s6_top[l]) >= CMP_W'(s5_den_reg);
            s6_div_next.rem[l]    = DEN_BITS'(s6_top[l]);
            s6_div_next.lo[l]     = s5_num_reg[l][QUOT_BITS-1:0];
            s6_div_next.neg[l]    = s5_neg_reg[l];
        end
        s6_div_next.den    = s5_den_reg;
        // strictly inside: in-circle determinant nonzero, same sign as orientation
        s6_div_next.in_circle = !s5_degen_reg && (s6_ic != '0)
                              && (s6_ic[IC_W-1] == s5_det_neg_reg);
        s6_div_next.degen  = s5_degen_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s6_div_reg <= s6_div_next;
        end
    end

    // ---------------------------------------------------------------------
    // Stages 7..38: pipelined restoring divider, both center lanes
    // ---------------------------------------------------------------------
    logic        div_valid;
    div_stage_t  div_out;

    ccit_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_reg[5]),
        .in_stage  (s6_div_reg),
        .out_valid (div_valid),
        .out_stage (div_out)
    );

    // ---------------------------------------------------------------------
    // Stage 39: saturate, apply sign, zero the center and other flags on a degenerate triangle
    // ---------------------------------------------------------------------
    logic [LANES-1:0][QUOT_BITS-1:0]  lim;
    logic [LANES-1:0][QUOT_BITS-1:0]  mag;
    logic [LANES-1:0][QUOT_BITS-1:0]  val;
    logic [LANES-1:0]                 clip;
    ccit_out_t                        m_word_next;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            lim[l]  = div_out.neg[l] ? SAT_NEG_MAG : SAT_POS_MAG;
            clip[l] = div_out.ovf[l] || (div_out.quot[l] > lim[l]);
            mag[l]  = clip[l] ? lim[l] : div_out.quot[l];
            val[l]  = div_out.neg[l] ? -mag[l] : mag[l];
        end
        m_word_next = '0;
        m_word_next.degenerate = div_out.degen;
        if (!div_out.degen) begin
            m_word_next.center_x   = val[LANE_X];
            m_word_next.center_y   = val[LANE_Y];
            m_word_next.inside_res = div_out.in_circle;
            m_word_next.saturated  = |clip;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_word_reg <= m_word_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule
`default_nettype wire

// ===== rtl/core/ccit_div.sv =====
`default_nettype none
module ccit_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  ccit_pkg::div_stage_t   in_stage,
    output logic                   out_valid,
    output ccit_pkg::div_stage_t   out_stage
);
    import ccit_pkg::*;

    div_stage_t             stg_reg  [DIV_STAGES];
    div_stage_t             stg_next [DIV_STAGES];
    logic [DIV_STAGES-1:0]  vld_reg;

    // one quotient bit per stage, both lanes share the divisor
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        div_stage_t              src;
        logic [LANES-1:0][DEN_BITS:0] shifted;

        if (g == 0) begin : g_first
            assign src = in_stage;
        end else begin : g_rest
            assign src = stg_reg[g-1];
        end

        always_comb begin
            stg_next[g] = src;
            for (int l = 0; l < LANES; l++) begin
                shifted[l] = {src.rem[l], src.lo[l][QUOT_BITS-1]};
                stg_next[g].lo[l] = {src.lo[l][QUOT_BITS-2:0], 1'b0};
                if (shifted[l] >= {1'b0, src.den}) begin
                    stg_next[g].rem[l]  = DEN_BITS'(shifted[l] - {1'b0, src.den});
                    stg_next[g].quot[l] = {src.quot[l][QUOT_BITS-2:0], 1'b1};
                end else begin
                    stg_next[g].rem[l]  = shifted[l][DEN_BITS-1:0];
                    stg_next[g].quot[l] = {src.quot[l][QUOT_BITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stg_reg[g] <= stg_next[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign out_stage = stg_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/core/ccit_checker.sv =====
`default_nettype none
module ccit_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_ready,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  ccit_pkg::ccit_out_t  m_word
);
    import ccit_pkg::*;

    // result word holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // output register empty: the pipe must take input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

    // degenerate triangle gives a zero center and no flags
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.degenerate |-> (m_word.center_x == '0)
            && (m_word.center_y == '0) && !m_word.inside_res && !m_word.saturated)
        else $error("degenerate result carries data");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

bind circumcircle_in_circle_test ccit_checker u_ccit_checker (.*);
`default_nettype wire
